@@ src/thrr_pkg.sv @@
// thrr_pkg: shared types for the two-hop route reachability block.
// Holds the opcode, the queued command word and the result word.
// No dependencies.
`timescale 1ns / 1ps

package thrr_pkg;

    localparam int NODE_W = 7;

    typedef logic [NODE_W-1:0] t_node;

    typedef enum logic {
        FUNC_ADD   = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // Command word after classification, as it sits in the queue.
    typedef struct packed {
        t_func func;
        t_node from_node;
        t_node to_node;
        logic  from_ok;    // from_node below NODES
        logic  to_ok;      // to_node below NODES
    } t_cmd;

    typedef struct packed {
        logic  direct_edge;
        logic  one_stop_found;
        t_node one_stop_via;
        logic  two_stop_found;
        t_node two_stop_first;
        t_node two_stop_second;
        logic  same_endpoints;
    } t_result;

endpackage

@@ src/thrr_front.sv @@
// thrr_front: input side of the reachability block. Classifies each
// accepted word (range checks) and holds it in a two-entry queue.
// Depends on thrr_pkg.
`timescale 1ns / 1ps

module thrr_front #(
    parameter int NODES = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_func,
    input  thrr_pkg::t_node i_from_node,
    input  thrr_pkg::t_node i_to_node,
    output logic           o_head_valid,
    output thrr_pkg::t_cmd o_head,
    input  logic           i_pop
);
    import thrr_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    always_comb begin
        w_cmd.func      = t_func'(i_func);
        w_cmd.from_node = i_from_node;
        w_cmd.to_node   = i_to_node;
        w_cmd.from_ok   = (32'(i_from_node) < NODES);
        w_cmd.to_ok     = (32'(i_to_node) < NODES);
    end

    assign o_in_ready   = (r_cnt != 2'd2);
    assign w_push       = i_in_valid && o_in_ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];

    always_comb begin
        case ({w_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ src/thrr_back.sv @@
// thrr_back: execution side. Holds the adjacency matrix and its transpose
// in two row memories, runs edge inserts and the scanning query engine,
// and drives the output register. Depends on thrr_pkg.
`timescale 1ns / 1ps

module thrr_back #(
    parameter int NODES = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  thrr_pkg::t_cmd    i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output thrr_pkg::t_result o_result
);
    import thrr_pkg::*;

    localparam int IW = $clog2(NODES);

    typedef logic [IW-1:0]    t_idx;
    typedef logic [NODES-1:0] t_row;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ADD_RD = 7'b0000010,
        S_ADD_WR = 7'b0000100,
        S_Q_RD   = 7'b0001000,
        S_Q_LOAD = 7'b0010000,
        S_SCAN   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    localparam t_idx LAST_IDX = t_idx'(NODES - 1);
    localparam t_row ONE_HOT0 = t_row'(1);

    t_state  r_state, n_state;
    t_cmd    r_cmd;
    t_idx    r_chk;

    // row memories and their per-row valid bits
    t_row    m_rows [NODES];
    t_row    m_cols [NODES];
    t_row    r_row_rd, r_col_rd;
    logic    r_row_rd_ok, r_col_rd_ok;
    t_row    r_row_valid, r_col_valid;

    t_row    r_src_row, r_dst_col, r_jmask;
    logic    r_direct;
    logic    r_one_found, r_two_found;
    t_node   r_one_via, r_two_first, r_two_second;

    logic    r_out_valid;
    t_result r_out;

    t_idx    w_from_idx, w_to_idx;
    t_row    w_from_hot, w_to_hot;
    t_idx    w_row_ra, w_col_ra;
    logic    w_row_ra_ok, w_col_ra_ok;
    logic    w_mem_we;
    logic    w_out_load;
    t_row    w_row_eff, w_col_eff;
    t_row    w_cand;
    logic    w_cand_any;
    t_idx    w_cand_pos;
    logic    w_k_is_dst;

    assign w_from_idx = t_idx'(r_cmd.from_node);
    assign w_to_idx   = t_idx'(r_cmd.to_node);
    assign w_from_hot = ONE_HOT0 << w_from_idx;
    assign w_to_hot   = ONE_HOT0 << w_to_idx;
    assign w_row_eff  = r_row_rd_ok ? r_row_rd : '0;
    assign w_col_eff  = r_col_rd_ok ? r_col_rd : '0;

    // sequencer
    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        w_mem_we    = 1'b0;
        w_out_load  = 1'b0;
        w_row_ra    = w_from_idx;
        w_row_ra_ok = r_cmd.from_ok;
        w_col_ra    = w_to_idx;
        w_col_ra_ok = r_cmd.to_ok;
        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    if (i_head.func == FUNC_QUERY) begin
                        n_state = S_Q_RD;
                    end else if (i_head.from_ok && i_head.to_ok) begin
                        n_state = S_ADD_RD;
                    end
                end
            end
            S_ADD_RD: n_state = S_ADD_WR;
            S_ADD_WR: begin
                w_mem_we = 1'b1;
                n_state  = S_IDLE;
            end
            S_Q_RD:   n_state = S_Q_LOAD;
            S_Q_LOAD: begin
                w_row_ra    = '0;
                w_row_ra_ok = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                w_row_ra    = r_chk + t_idx'(1);
                w_row_ra_ok = (r_chk != LAST_IDX);
                if (r_chk == LAST_IDX) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // second-hop candidates of the row just read, lowest one first
    assign w_cand     = w_row_eff & r_jmask;
    assign w_cand_any = |w_cand;
    assign w_k_is_dst = (32'(r_chk) == 32'(r_cmd.to_node));

    always_comb begin
        w_cand_pos = '0;
        for (int b = NODES - 1; b >= 0; b--) begin
            if (w_cand[b]) begin
                w_cand_pos = t_idx'(b);
            end
        end
    end

    // memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            m_rows[w_from_idx] <= w_row_eff | w_to_hot;
            m_cols[w_to_idx]   <= w_col_eff | w_from_hot;
        end
        r_row_rd <= m_rows[w_row_ra];
        r_col_rd <= m_cols[w_col_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_col_valid <= '0;
            r_row_rd_ok <= 1'b0;
            r_col_rd_ok <= 1'b0;
        end else begin
            if (w_mem_we) begin
                r_row_valid[w_from_idx] <= 1'b1;
                r_col_valid[w_to_idx]   <= 1'b1;
            end
            r_row_rd_ok <= w_row_ra_ok && r_row_valid[w_row_ra];
            r_col_rd_ok <= w_col_ra_ok && r_col_valid[w_col_ra];
        end
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        case (r_state)
            S_Q_LOAD: begin
                r_src_row    <= w_row_eff;
                r_dst_col    <= w_col_eff;
                r_jmask      <= w_col_eff & ~w_from_hot;
                r_direct     <= w_row_eff[w_to_idx] && r_cmd.to_ok;
                r_one_found  <= 1'b0;
                r_one_via    <= '0;
                r_two_found  <= 1'b0;
                r_two_first  <= '0;
                r_two_second <= '0;
                r_chk        <= '0;
            end
            S_SCAN: begin
                r_chk <= r_chk + t_idx'(1);
                if (!r_one_found && r_src_row[r_chk] && r_dst_col[r_chk]) begin
                    r_one_found <= 1'b1;
                    r_one_via   <= t_node'(r_chk);
                end
                if (!r_two_found && r_src_row[r_chk] && !w_k_is_dst && w_cand_any) begin
                    r_two_found  <= 1'b1;
                    r_two_first  <= t_node'(r_chk);
                    r_two_second <= t_node'(w_cand_pos);
                end
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out.direct_edge     <= r_direct;
            r_out.one_stop_found  <= r_one_found;
            r_out.one_stop_via    <= r_one_via;
            r_out.two_stop_found  <= r_two_found;
            r_out.two_stop_first  <= r_two_first;
            r_out.two_stop_second <= r_two_second;
            r_out.same_endpoints  <= (r_cmd.from_node == r_cmd.to_node);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_out_load || (r_out_valid && !i_out_ready);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word raised outside the completion step");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_cmd.from_ok && r_cmd.to_ok && r_cmd.func == FUNC_ADD))
        else $error("matrix write for an out-of-range or non-add command");

    a_one_stop_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_one_found) |->
            (r_src_row[t_idx'(r_one_via)] && r_dst_col[t_idx'(r_one_via)]))
        else $error("one-stop node lacks an edge");

    a_two_stop_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_two_found) |->
            (r_src_row[t_idx'(r_two_first)] && r_dst_col[t_idx'(r_two_second)]
             && (r_two_second != r_cmd.from_node) && (r_two_first != r_cmd.to_node)))
        else $error("two-stop path breaks an edge or endpoint rule");

endmodule

@@ src/two_hop_route_reachability.sv @@
// two_hop_route_reachability: top level, directed reachability over an
// adjacency bit matrix. Instantiates thrr_front and thrr_back; uses thrr_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one word per handshake:
//   i_func = 0 adds edge i_from_node -> i_to_node (no result word);
//   i_func = 1 queries the pair and yields exactly one result word.
//   Output channel (o_out_valid / i_out_ready) carries the query result.
//   Adds naming a node at or beyond NODES are dropped; such a node has no
//   edges in a query. same_endpoints compares the raw node fields.
// Timing
//   Words land in a two-entry queue; the engine takes one word at a time.
//   An add passes the engine through pop, row read and row write.
//   A query passes it through pop, reads of the source row and
//   destination column, then one adjacency row per cycle for all NODES
//   candidates, then the result load. The row memory's single read port
//   sets that scan rate.
// Reset and stalls
//   Reset clears per-row valid bits, so the matrix reads empty at once; no
//   clearing pass. A stalled receiver holds the result word in the output
//   register; the engine keeps working on the next word and waits only
//   when it has another result to load. The queue absorbs two more words.
`timescale 1ns / 1ps

module two_hop_route_reachability #(
    parameter int NODES = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_func,
    input  thrr_pkg::t_node i_from_node,
    input  thrr_pkg::t_node i_to_node,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_direct_edge,
    output logic            o_one_stop_found,
    output thrr_pkg::t_node o_one_stop_via,
    output logic            o_two_stop_found,
    output thrr_pkg::t_node o_two_stop_first,
    output thrr_pkg::t_node o_two_stop_second,
    output logic            o_same_endpoints
);
    import thrr_pkg::*;

    logic    w_head_valid;
    t_cmd    w_head;
    logic    w_pop;
    t_result w_result;

    // front: classify and queue incoming words
    thrr_front #(
        .NODES(NODES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_from_node  (i_from_node),
        .i_to_node    (i_to_node),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // back: matrix storage, insert and scan engine, output register
    thrr_back #(
        .NODES(NODES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (w_result)
    );

    assign o_direct_edge     = w_result.direct_edge;
    assign o_one_stop_found  = w_result.one_stop_found;
    assign o_one_stop_via    = w_result.one_stop_via;
    assign o_two_stop_found  = w_result.two_stop_found;
    assign o_two_stop_first  = w_result.two_stop_first;
    assign o_two_stop_second = w_result.two_stop_second;
    assign o_same_endpoints  = w_result.same_endpoints;

endmodule
